FILE: src/bbd_pkg.sv
package bbd_pkg;

	localparam int SCAN_W    = 32;
	localparam int TIME_IN_W = 32;
	localparam int IDX_W     = 5;
	localparam int DELAY_W   = 16;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd50;

	// word index of each register (paddr[2])
	typedef enum logic {
		REG_DEBOUNCE_DELAY = 1'b0
	} reg_idx_t;

endpackage

FILE: src/bbd_if.sv
interface bbd_in_if import bbd_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [SCAN_W-1:0]    scan_bits;
	logic [TIME_IN_W-1:0] time_now;

	modport source (output valid, scan_bits, time_now, input ready);
	modport sink   (input valid, scan_bits, time_now, output ready);
endinterface

interface bbd_out_if import bbd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] button_index;
	logic             pressed;
	logic             last_event;

	modport source (output valid, button_index, pressed, last_event, input ready);
	modport sink   (input valid, button_index, pressed, last_event, output ready);
endinterface

FILE: src/bbd_lane.sv
module bbd_lane import bbd_pkg::*; #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  level,
	input  logic [TIME_WIDTH-1:0] now,
	input  logic [DELAY_W-1:0]    delay,
	output logic                  evt
);

	logic                  level_q;
	logic [TIME_WIDTH-1:0] change_time_q;
	logic [TIME_WIDTH-1:0] elapsed;

	assign elapsed = now - change_time_q;
	assign evt     = (elapsed > TIME_WIDTH'(delay)) && (level != level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= 1'b0;
			change_time_q <= '0;
		end else if (load && evt) begin
			level_q       <= level;
			change_time_q <= now;
		end
	end

endmodule

FILE: src/bbd_merge.sv
module bbd_merge import bbd_pkg::*; #(
	parameter int BUTTONS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [BUTTONS-1:0] evt,
	input  logic [BUTTONS-1:0] levels,
	output logic               busy,
	bbd_out_if.source          ev
);

	logic [BUTTONS-1:0] pend_q;
	logic [BUTTONS-1:0] lvl_q;
	logic [BUTTONS-1:0] pick;
	logic [IDX_W-1:0]   pick_idx;
	logic               pick_lvl;
	logic               take;
	logic               emit;
	logic               valid_q;
	logic [IDX_W-1:0]   idx_q;
	logic               pressed_q;
	logic               last_q;

	assign pick = pend_q & (~pend_q + BUTTONS'(1));
	assign busy = |pend_q;
	assign take = !valid_q || ev.ready;
	assign emit = take && busy;

	always_comb begin
		pick_idx = '0;
		pick_lvl = 1'b0;
		for (int i = BUTTONS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				pick_idx = IDX_W'(i);
				pick_lvl = lvl_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= evt;
			end else if (emit) begin
				pend_q <= pend_q & ~pick;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (ev.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lvl_q <= levels;
		end
		if (emit) begin
			idx_q     <= pick_idx;
			pressed_q <= pick_lvl;
			last_q    <= ((pend_q & ~pick) == '0);
		end
	end

	assign ev.valid        = valid_q;
	assign ev.button_index = idx_q;
	assign ev.pressed      = pressed_q;
	assign ev.last_event   = last_q;

endmodule

FILE: src/button_bank_debounce_events_top.sv
// channel    | dir | handshake      | word
// scan_in    | in  | valid/ready    | scan_bits[31:0], time_now[31:0]
// event_out  | out | valid/ready    | button_index[4:0], pressed, last_event
// apb        | in  | psel/penable   | debounce_delay at 0x0
//
// A scan is taken in one handshake; all lanes test and update in parallel.
// Events then leave one per cycle from the output register while event_out is
// ready, lowest button first. scan_in.ready is low while any event is pending,
// so event_out stalls hold it low too. Only the 32 scanned buttons can change.
// Reset clears levels and change times and sets the delay to 50.
module button_bank_debounce_events_top import bbd_pkg::*; #(
	parameter int NUM_BYTES  = 4,
	parameter int TIME_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	bbd_in_if.sink            scan_in,
	bbd_out_if.source         event_out
);

	localparam int BUTTONS = NUM_BYTES * 8;
	localparam int TW_IN   = (TIME_WIDTH < TIME_IN_W) ? TIME_WIDTH : TIME_IN_W;

	logic [DELAY_W-1:0]    delay_q;
	logic [TIME_WIDTH-1:0] now;
	logic [BUTTONS-1:0]    evt;
	logic [BUTTONS-1:0]    levels;
	logic                  load;
	logic                  busy;
	reg_idx_t              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (psel && penable && pwrite && reg_sel == REG_DEBOUNCE_DELAY) begin
			delay_q <= pwdata[DELAY_W-1:0];
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DEBOUNCE_DELAY: prdata = DATA_W'(delay_q);
			default:            prdata = '0;
		endcase
	end

	assign scan_in.ready = !busy;
	assign load          = scan_in.valid && !busy;
	assign now           = TIME_WIDTH'(scan_in.time_now[TW_IN-1:0]);

	for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
		logic lvl;
		if (i < SCAN_W) begin : g_in
			assign lvl = scan_in.scan_bits[i];
		end else begin : g_zero
			assign lvl = 1'b0;
		end
		bbd_lane #(
			.TIME_WIDTH(TIME_WIDTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (load),
			.level   (lvl),
			.now     (now),
			.delay   (delay_q),
			.evt     (evt[i])
		);
		assign levels[i] = lvl;
	end

	bbd_merge #(
		.BUTTONS(BUTTONS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.evt    (evt),
		.levels (levels),
		.busy   (busy),
		.ev     (event_out)
	);

endmodule

FILE: test/testbench.sv
module testbench;
	import bbd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_SCANS = 38;
	localparam logic [ADDR_W-1:0] DELAY_ADDR = {REG_DEBOUNCE_DELAY, 2'b00};
	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

	typedef struct {
		logic [SCAN_W-1:0]    bits;
		logic [TIME_IN_W-1:0] stamp;
	} scan_word_t;

	typedef struct {
		logic [IDX_W-1:0] button_index;
		logic             pressed;
		logic             last_event;
	} button_event_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	bbd_in_if  scan_in ();
	bbd_out_if event_out ();

	button_bank_debounce_events_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.scan_in   (scan_in),
		.event_out (event_out)
	);

	// debouncer shadow state
	logic [DELAY_W-1:0]   lockout_ms;
	logic                 btn_level [SCAN_W];
	logic [TIME_IN_W-1:0] btn_change_time [SCAN_W];

	scan_word_t    scan_queue [$];
	button_event_t awaited_events [$];
	scan_word_t    next_scan;
	button_event_t seen_event;
	button_event_t want_event;

	int unsigned scans_queued = 0;
	int unsigned scans_taken = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;

	logic [SCAN_W-1:0]    gen_bits;
	logic [TIME_IN_W-1:0] gen_time;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void debounce_scan(logic [SCAN_W-1:0] bits, logic [TIME_IN_W-1:0] now);
		logic [TIME_IN_W-1:0] elapsed;
		button_event_t        ev;
		int                   n;
		n = 0;
		for (int i = 0; i < SCAN_W; i++) begin
			elapsed = now - btn_change_time[i];
			if (elapsed > TIME_IN_W'(lockout_ms) && bits[i] != btn_level[i]) begin
				ev.button_index = IDX_W'(i);
				ev.pressed = bits[i];
				ev.last_event = 1'b0;
				awaited_events.push_back(ev);
				btn_level[i] = bits[i];
				btn_change_time[i] = now;
				n++;
			end
		end
		if (n > 0)
			awaited_events[$].last_event = 1'b1;
	endfunction

	// scan source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_in.valid <= 1'b0;
			scan_in.scan_bits <= '0;
			scan_in.time_now <= '0;
		end else begin
			if (scan_in.valid && scan_in.ready) begin
				debounce_scan(scan_in.scan_bits, scan_in.time_now);
				scans_taken++;
			end
			if (!scan_in.valid || scan_in.ready) begin
				if (scan_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					next_scan = scan_queue.pop_front();
					scan_in.valid <= 1'b1;
					scan_in.scan_bits <= next_scan.bits;
					scan_in.time_now <= next_scan.stamp;
				end else begin
					scan_in.valid <= 1'b0;
				end
			end
		end
	end

	// event sink and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_out.ready <= 1'b0;
		end else begin
			if (event_out.valid && event_out.ready) begin
				seen_event.button_index = event_out.button_index;
				seen_event.pressed = event_out.pressed;
				seen_event.last_event = event_out.last_event;
				if (awaited_events.size() == 0) begin
					$error("unexpected event word: button_index %0d pressed %0d last_event %0d",
						seen_event.button_index, seen_event.pressed, seen_event.last_event);
					fail_count++;
				end else begin
					want_event = awaited_events.pop_front();
					if (seen_event.button_index !== want_event.button_index) begin
						$error("button_index mismatch: expected %0d, got %0d",
							want_event.button_index, seen_event.button_index);
						fail_count++;
					end
					if (seen_event.pressed !== want_event.pressed) begin
						$error("pressed mismatch: expected %0d, got %0d",
							want_event.pressed, seen_event.pressed);
						fail_count++;
					end
					if (seen_event.last_event !== want_event.last_event) begin
						$error("last_event mismatch: expected %0d, got %0d",
							want_event.last_event, seen_event.last_event);
						fail_count++;
					end
				end
			end
			event_out.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx_t'(addr[2]) == REG_DEBOUNCE_DELAY)
			lockout_ms = data[DELAY_W-1:0];
	endtask

	task automatic check_lockout();
		logic [DATA_W-1:0] data;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= DELAY_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (data[DELAY_W-1:0] !== lockout_ms) begin
			$error("debounce_delay mismatch: expected %0d, got %0d", lockout_ms,
				data[DELAY_W-1:0]);
			fail_count++;
		end
	endtask

	task automatic push_scan(input logic [SCAN_W-1:0] bits, input logic [TIME_IN_W-1:0] stamp);
		scan_word_t w;
		w.bits = bits;
		w.stamp = stamp;
		scan_queue.push_back(w);
		scans_queued++;
	endtask

	// mostly plausible button activity: one, some or all bits flip, time mostly moves forward
	task automatic push_random_scan();
		int unsigned       pick;
		logic [SCAN_W-1:0] flips;
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0: flips = SCAN_W'(1) << $urandom_range(SCAN_W - 1);
			1: flips = $urandom & $urandom;
			2: flips = $urandom;
			default: flips = '1;
		endcase
		if (pick < 10) begin
			gen_bits = $urandom;
			gen_time = $urandom;
		end else begin
			gen_bits = gen_bits ^ flips;
			if (pick < 40)
				gen_time = gen_time + TIME_IN_W'($urandom_range(lockout_ms));
			else if (pick < 60)
				gen_time = gen_time + TIME_IN_W'(lockout_ms) + TIME_IN_W'($urandom_range(3)) - 1;
			else
				gen_time = gen_time + TIME_IN_W'(lockout_ms) + 1 + TIME_IN_W'($urandom_range(300));
		end
		push_scan(gen_bits, gen_time);
	endtask

	task automatic wait_idle();
		while (scans_taken != scans_queued || awaited_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [DELAY_W-1:0] settings [8];
		settings = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd50, 16'd0, 16'hFFFF, 16'd0};
		settings[3] = DELAY_W'($urandom);
		settings[5] = DELAY_W'($urandom_range(200));
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		lockout_ms = DELAY_RESET;
		for (int i = 0; i < SCAN_W; i++) begin
			btn_level[i] = 1'b0;
			btn_change_time[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		check_lockout();

		// start-up lockout, lockout boundary, all buttons at once, wrap of the timestamp
		push_scan(32'hFFFF_FFFF, 32'd0);
		push_scan(32'hFFFF_FFFF, 32'd50);
		push_scan(32'hFFFF_FFFF, 32'd51);
		push_scan(32'h0000_0000, 32'd60);
		push_scan(32'h0000_0000, 32'd101);
		push_scan(32'h0000_0000, 32'd102);
		push_scan(32'h8000_0001, 32'd153);
		push_scan(32'h0000_0002, 32'd154);
		push_scan(32'h5555_5555, 32'hFFFF_FFF0);
		push_scan(32'hAAAA_AAAA, 32'h0000_0010);
		push_scan(32'hAAAA_AAAA, 32'h0000_0040);
		push_scan(32'hAAAA_AAAA, 32'h0000_0040);
		push_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_scan(32'h0000_0000, 32'hFFFF_FFFF);
		push_scan(32'h0000_0000, 32'h7FFF_FFFF);
		wait_idle();

		gen_bits = '0;
		gen_time = 32'h7FFF_FFFF;
		for (int ph = 0; ph < 8; ph++) begin
			apb_write(DELAY_ADDR, {16'($urandom), settings[ph]});
			check_lockout();
			if (ph == 3) begin
				apb_write(UNMAPPED_ADDR, $urandom);
				check_lockout();
			end
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
				default: begin src_idle_pct = 15; snk_stall_pct = 15; end
			endcase
			for (int n = 0; n < PHASE_SCANS; n++)
				push_random_scan();
			wait_idle();
		end

		src_idle_pct = 0;
		snk_stall_pct = 0;
		wait_idle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
